>>> rtl/hsv2rgb_pkg.sv
package hsv2rgb_pkg;

  localparam int unsigned CompW = 16;
  localparam int unsigned SecW  = 3;

  localparam logic [CompW-1:0] ONE_Q15  = 16'd32768;
  localparam logic [CompW:0]   FRAC_ONE = 17'd65536;

  typedef enum logic [SecW-1:0] {
    SEC_RED_YEL  = 3'd0,
    SEC_YEL_GRN  = 3'd1,
    SEC_GRN_CYN  = 3'd2,
    SEC_CYN_BLU  = 3'd3,
    SEC_BLU_MAG  = 3'd4,
    SEC_MAG_RED  = 3'd5
  } sector_t;

  // after hue scaling and input clamping
  typedef struct packed {
    logic [SecW-1:0]  sector;
    logic [CompW-1:0] frac;
    logic [CompW-1:0] sat;
    logic [CompW-1:0] val;
  } prep_t;

  // after the saturation products
  typedef struct packed {
    logic [SecW-1:0]  sector;
    logic [CompW-1:0] sat;
    logic [CompW-1:0] val;
    logic [CompW-1:0] x_q;
    logic [CompW-1:0] x_t;
  } frac_t;

  // after the brightness products
  typedef struct packed {
    logic [SecW-1:0]  sector;
    logic             grey;
    logic [CompW-1:0] val;
    logic [CompW-1:0] p;
    logic [CompW-1:0] q;
    logic [CompW-1:0] t;
  } scaled_t;

  function automatic logic [CompW-1:0] sat_q15(input logic [CompW-1:0] x);
    return (x > ONE_Q15) ? ONE_Q15 : x;
  endfunction

endpackage

>>> rtl/hsv2rgb_prep.sv
module hsv2rgb_prep
  import hsv2rgb_pkg::*;
(
  input  logic             clk,
  input  logic             en,
  input  logic [CompW-1:0] hue,
  input  logic [CompW-1:0] saturation,
  input  logic [CompW-1:0] brightness,
  output prep_t            prep_r
);

  logic [CompW+2:0] h6;
  prep_t            prep_nxt;

  // hue * 6 = hue * 4 + hue * 2
  assign h6 = {1'b0, hue, 2'b00} + {2'b00, hue, 1'b0};

  always_comb begin
    prep_nxt.sector = h6[CompW+2:CompW];
    prep_nxt.frac   = h6[CompW-1:0];
    prep_nxt.sat    = sat_q15(saturation);
    prep_nxt.val    = sat_q15(brightness);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prep_r <= prep_nxt;
    end
  end

endmodule

>>> rtl/hsv2rgb_frac_mul.sv
module hsv2rgb_frac_mul
  import hsv2rgb_pkg::*;
(
  input  logic  clk,
  input  logic  en,
  input  prep_t prep,
  output frac_t frac_r
);

  logic [CompW:0]     inv_frac;
  logic [2*CompW-1:0] prod_q;
  logic [2*CompW:0]   prod_t;
  frac_t              frac_nxt;

  assign inv_frac = FRAC_ONE - {1'b0, prep.frac};
  assign prod_q   = prep.sat * prep.frac;
  assign prod_t   = {1'b0, prep.sat} * inv_frac;

  always_comb begin
    frac_nxt.sector = prep.sector;
    frac_nxt.sat    = prep.sat;
    frac_nxt.val    = prep.val;
    // both products stay at or below 1.0 in Q1.15 after the shift
    frac_nxt.x_q    = prod_q[2*CompW-1:CompW];
    frac_nxt.x_t    = prod_t[2*CompW-1:CompW];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      frac_r <= frac_nxt;
    end
  end

endmodule

>>> rtl/hsv2rgb_scale.sv
module hsv2rgb_scale
  import hsv2rgb_pkg::*;
(
  input  logic    clk,
  input  logic    en,
  input  frac_t   frac,
  output scaled_t scaled_r
);

  logic [CompW-1:0]   om_p, om_q, om_t;
  logic [2*CompW-1:0] prod_p, prod_q, prod_t;
  scaled_t            scaled_nxt;

  assign om_p = ONE_Q15 - frac.sat;
  assign om_q = ONE_Q15 - frac.x_q;
  assign om_t = ONE_Q15 - frac.x_t;

  assign prod_p = frac.val * om_p;
  assign prod_q = frac.val * om_q;
  assign prod_t = frac.val * om_t;

  always_comb begin
    scaled_nxt.sector = frac.sector;
    scaled_nxt.grey   = (frac.sat == '0);
    scaled_nxt.val    = frac.val;
    scaled_nxt.p      = prod_p[2*CompW-2:CompW-1];
    scaled_nxt.q      = prod_q[2*CompW-2:CompW-1];
    scaled_nxt.t      = prod_t[2*CompW-2:CompW-1];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      scaled_r <= scaled_nxt;
    end
  end

endmodule

>>> rtl/hsv_to_rgb_converter_core.sv
// channel  | ports                                          | dir
// input    | in_valid in_ready in_hue in_saturation         | in
//          | in_brightness                                  |
// result   | out_valid out_ready out_red out_green out_blue | out
//
// Four register stages: hue scaling, saturation products, brightness
// products, sector select into the output register. One transaction per
// cycle sustained while the output is not stalled.
// rst_n (synchronous, active low) clears the stage valid bits only.
// Each stage holds while the next one is full and stalled, so bubbles
// are squeezed out; input stalls only once all four stages are full.
module hsv_to_rgb_converter_core
  import hsv2rgb_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [CompW-1:0] in_hue,
  input  logic [CompW-1:0] in_saturation,
  input  logic [CompW-1:0] in_brightness,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [CompW-1:0] out_red,
  output logic [CompW-1:0] out_green,
  output logic [CompW-1:0] out_blue
);

  logic    v1_r, v2_r, v3_r, vo_r;
  logic    v1_nxt, v2_nxt, v3_nxt, vo_nxt;
  logic    rdy1, rdy2, rdy3, rdy4;
  prep_t   prep_r;
  frac_t   frac_r;
  scaled_t scaled_r;
  logic [CompW-1:0] red_r, green_r, blue_r;
  logic [CompW-1:0] red_nxt, green_nxt, blue_nxt;

  assign rdy4 = !vo_r || out_ready;
  assign rdy3 = !v3_r || rdy4;
  assign rdy2 = !v2_r || rdy3;
  assign rdy1 = !v1_r || rdy2;

  assign v1_nxt = rdy1 ? in_valid : v1_r;
  assign v2_nxt = rdy2 ? v1_r : v2_r;
  assign v3_nxt = rdy3 ? v2_r : v3_r;
  assign vo_nxt = rdy4 ? v3_r : vo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      vo_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
      v3_r <= v3_nxt;
      vo_r <= vo_nxt;
    end
  end

  hsv2rgb_prep u_prep (
    .clk        (clk),
    .en         (rdy1),
    .hue        (in_hue),
    .saturation (in_saturation),
    .brightness (in_brightness),
    .prep_r     (prep_r)
  );

  hsv2rgb_frac_mul u_frac_mul (
    .clk    (clk),
    .en     (rdy2),
    .prep   (prep_r),
    .frac_r (frac_r)
  );

  hsv2rgb_scale u_scale (
    .clk      (clk),
    .en       (rdy3),
    .frac     (frac_r),
    .scaled_r (scaled_r)
  );

  always_comb begin
    red_nxt   = scaled_r.val;
    green_nxt = scaled_r.val;
    blue_nxt  = scaled_r.val;
    if (!scaled_r.grey) begin
      unique case (scaled_r.sector)
        SEC_RED_YEL: begin
          red_nxt = scaled_r.val; green_nxt = scaled_r.t;   blue_nxt = scaled_r.p;
        end
        SEC_YEL_GRN: begin
          red_nxt = scaled_r.q;   green_nxt = scaled_r.val; blue_nxt = scaled_r.p;
        end
        SEC_GRN_CYN: begin
          red_nxt = scaled_r.p;   green_nxt = scaled_r.val; blue_nxt = scaled_r.t;
        end
        SEC_CYN_BLU: begin
          red_nxt = scaled_r.p;   green_nxt = scaled_r.q;   blue_nxt = scaled_r.val;
        end
        SEC_BLU_MAG: begin
          red_nxt = scaled_r.t;   green_nxt = scaled_r.p;   blue_nxt = scaled_r.val;
        end
        default: begin
          red_nxt = scaled_r.val; green_nxt = scaled_r.p;   blue_nxt = scaled_r.q;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rdy4) begin
      red_r   <= red_nxt;
      green_r <= green_nxt;
      blue_r  <= blue_nxt;
    end
  end

  assign in_ready  = rdy1;
  assign out_valid = vo_r;
  assign out_red   = red_r;
  assign out_green = green_r;
  assign out_blue  = blue_r;

endmodule

>>> rtl/hsv2rgb_checker.sv
module hsv2rgb_checker
  import hsv2rgb_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic [CompW-1:0] out_red,
  input logic [CompW-1:0] out_green,
  input logic [CompW-1:0] out_blue
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_red) &&
      $stable(out_green) && $stable(out_blue))
    else $error("stalled result changed");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_red <= ONE_Q15 && out_green <= ONE_Q15 && out_blue <= ONE_Q15)
    else $error("component above 1.0");

  // with the output free the whole pipe can move
  a_no_block: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid || out_ready |-> in_ready)
    else $error("input blocked while output free");

  // an accepted input reaches the output when nothing stalls
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    $past(in_valid && in_ready, 4) && $past(out_ready, 1) && $past(out_ready, 2) &&
      $past(out_ready, 3) && $past(rst_n, 1) && $past(rst_n, 2) &&
      $past(rst_n, 3) && $past(rst_n, 4) |-> out_valid)
    else $error("transaction lost in pipeline");

endmodule

bind hsv_to_rgb_converter_core hsv2rgb_checker u_hsv2rgb_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_red   (out_red),
  .out_green (out_green),
  .out_blue  (out_blue)
);
